// ===== rtl/core/lfpd_pkg.sv =====
// shared types and constants of the pd line-follower drive unit
package lfpd_pkg;

	localparam int NUM_SENSORS = 5;
	localparam int ERR_W       = 4;
	localparam int DUTY_W      = 8;
	localparam int KP_W        = 10;
	localparam int KD_W        = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int OUT_W       = 24;
	localparam int QDEPTH      = 2;

	localparam logic [KP_W-1:0]   KP_RESET    = 10'd600;
	localparam logic [KD_W-1:0]   KD_RESET    = 12'd2907;
	localparam logic [DUTY_W-1:0] BASE_RESET  = 8'd121;
	localparam int                THRESH_RESET = 2000;
	localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_DERIV_GAIN     = 3'd1,
		REG_BASE_SPEED     = 3'd2,
		REG_LINE_THRESHOLD = 3'd3,
		REG_DRIVE_ENABLE   = 3'd4
	} cfg_reg_t;

	// classified sample set handed from front to back
	typedef struct packed {
		logic                    any_hit;
		logic signed [ERR_W-1:0] err;
		logic                    center;
		logic                    lifted;
	} fe_word_t;

endpackage

// ===== rtl/core/line_follow_pd_drive_unit.sv =====
// pd line-follower drive unit: top level with configuration registers
// an accepted word goes through the queue and the s1 and s2 registers to m_axis
// throughput: one sample set per cycle unless stalled, limited by error hold loop
// a two-entry queue lets input keep flowing while the output stalls, until full
// reset: arst_n clears the queue, pipeline valids and held error, and loads
// the register defaults (gains 600 and 2907, base 121, threshold 2000, drive off)
module line_follow_pd_drive_unit #(
	parameter int SAMPLE_BITS = 12,
	parameter int GAIN_FRAC_BITS = 4,
	parameter int IN_W = ((5 * SAMPLE_BITS + 7) / 8) * 8,
	parameter int CFG_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// far_left, left, center, right, far_right, zero pad
	input  logic [IN_W-1:0]                   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// duty_motor_a[7:0], duty_motor_b[15:8], line_error[19:16], lifted[20], zero pad
	output logic [lfpd_pkg::OUT_W-1:0]        m_axis_tdata,
	input  logic                              cfg_wr_en,
	input  logic [lfpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]                  cfg_wdata
);
	import lfpd_pkg::*;

	logic [KP_W-1:0]        prop_gain_q;
	logic [KD_W-1:0]        deriv_gain_q;
	logic [DUTY_W-1:0]      base_speed_q;
	logic [SAMPLE_BITS-1:0] threshold_q;
	logic                   drive_enable_q;

	fe_word_t front_word;
	fe_word_t head_word;
	logic     q_full;
	logic     push;
	logic     head_valid;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= KP_RESET;
			deriv_gain_q   <= KD_RESET;
			base_speed_q   <= BASE_RESET;
			threshold_q    <= SAMPLE_BITS'(THRESH_RESET);
			drive_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN: begin
					prop_gain_q <= cfg_wdata[KP_W-1:0];
				end
				REG_DERIV_GAIN: begin
					deriv_gain_q <= cfg_wdata[KD_W-1:0];
				end
				REG_BASE_SPEED: begin
					base_speed_q <= cfg_wdata[DUTY_W-1:0];
				end
				REG_LINE_THRESHOLD: begin
					threshold_q <= cfg_wdata[SAMPLE_BITS-1:0];
				end
				REG_DRIVE_ENABLE: begin
					drive_enable_q <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && s_axis_tready;

	lfpd_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.IN_W(IN_W)
	) u_front (
		.tdata(s_axis_tdata),
		.threshold(threshold_q),
		.word(front_word)
	);

	lfpd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_word(front_word),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_word(head_word)
	);

	lfpd_back #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(head_valid),
		.q_word(head_word),
		.q_pop(pop),
		.prop_gain(prop_gain_q),
		.deriv_gain(deriv_gain_q),
		.base_speed(base_speed_q),
		.drive_enable(drive_enable_q),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

endmodule

// ===== rtl/core/lfpd_front.sv =====
// front end: thresholds the five samples and classifies the pattern
module lfpd_front #(
	parameter int SAMPLE_BITS = 12,
	parameter int IN_W = 64
) (
	input  logic [IN_W-1:0]        tdata,
	input  logic [SAMPLE_BITS-1:0] threshold,
	output lfpd_pkg::fe_word_t     word
);
	import lfpd_pkg::*;

	logic [SAMPLE_BITS-1:0] smp [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] hit;
	logic [NUM_SENSORS-1:0] full;
	logic                   left_side;
	logic                   right_side;
	logic [2:0]             mag_l;
	logic [2:0]             mag_r;

	for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_smp
		assign smp[i]  = tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
		assign hit[i]  = smp[i] > threshold;
		assign full[i] = smp[i] == {SAMPLE_BITS{1'b1}};
	end

	assign left_side  = hit[0] | hit[1];
	assign right_side = hit[3] | hit[4];
	assign mag_l = (hit[0] ? 3'd3 : 3'd0) + (hit[1] ? 3'd2 : 3'd0) + {2'b00, hit[2]};
	assign mag_r = (hit[4] ? 3'd3 : 3'd0) + (hit[3] ? 3'd2 : 3'd0) + {2'b00, hit[2]};

	always_comb begin
		word.any_hit = |hit;
		word.center  = hit[2];
		word.lifted  = &full;
		if (left_side && !right_side) begin
			word.err = -$signed({1'b0, mag_l});
		end else if (right_side && !left_side) begin
			word.err = $signed({1'b0, mag_r});
		end else begin
			word.err = '0;
		end
	end

endmodule

// ===== rtl/core/lfpd_queue.sv =====
// short queue between the classifying front and the pd back end
module lfpd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  lfpd_pkg::fe_word_t push_word,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output lfpd_pkg::fe_word_t head_word
);
	import lfpd_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	fe_word_t         mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/lfpd_back.sv =====
// back end: resolves the held error, pd correction and duty saturation
module lfpd_back #(
	parameter int GAIN_FRAC_BITS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  lfpd_pkg::fe_word_t           q_word,
	output logic                         q_pop,
	input  logic [lfpd_pkg::KP_W-1:0]    prop_gain,
	input  logic [lfpd_pkg::KD_W-1:0]    deriv_gain,
	input  logic [lfpd_pkg::DUTY_W-1:0]  base_speed,
	input  logic                         drive_enable,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [lfpd_pkg::OUT_W-1:0]   m_axis_tdata
);
	import lfpd_pkg::*;

	localparam int P_W     = KP_W + ERR_W + 1;
	localparam int D_W     = KD_W + ERR_W + 2;
	localparam int SCALE_W = DUTY_W + GAIN_FRAC_BITS;
	localparam int SUM_W   = ((SCALE_W > D_W) ? SCALE_W : D_W) + 2;

	logic signed [ERR_W-1:0] last_error_q;
	logic signed [ERR_W-1:0] e_res;
	logic signed [ERR_W:0]   e_diff;
	logic signed [P_W-1:0]   p_prod;
	logic signed [D_W-1:0]   d_prod;
	logic                    advance_s1;
	logic                    advance_s2;

	logic                    valid_s1;
	logic signed [ERR_W-1:0] e_s1;
	logic signed [P_W-1:0]   p_s1;
	logic signed [D_W-1:0]   d_s1;
	logic                    center_s1;
	logic                    lifted_s1;
	logic                    en_s1;

	logic [SCALE_W-1:0]      base_scaled;
	logic signed [SUM_W-1:0] base_w;
	logic signed [SUM_W-1:0] corr;
	logic signed [SUM_W-1:0] sum_a;
	logic signed [SUM_W-1:0] sum_b;
	logic [DUTY_W-1:0]       high_speed;
	logic [DUTY_W-1:0]       duty_a;
	logic [DUTY_W-1:0]       duty_b;

	logic                    valid_s2;
	logic [DUTY_W-1:0]       duty_a_s2;
	logic [DUTY_W-1:0]       duty_b_s2;
	logic signed [ERR_W-1:0] e_s2;
	logic                    lifted_s2;

	function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] sh;
		sh = v >>> GAIN_FRAC_BITS;
		if (v < 0) begin
			sat_duty = '0;
		end else if (sh > $signed(SUM_W'(DUTY_MAX))) begin
			sat_duty = DUTY_MAX;
		end else begin
			sat_duty = sh[DUTY_W-1:0];
		end
	endfunction

	assign advance_s2 = !valid_s2 || m_axis_tready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign q_pop      = q_valid && advance_s1;

	// no line seen: keep the previous error
	assign e_res  = q_word.any_hit ? q_word.err : last_error_q;
	assign e_diff = (ERR_W+1)'(e_res) - (ERR_W+1)'(last_error_q);
	assign p_prod = P_W'($signed({1'b0, prop_gain})) * P_W'(e_res);
	assign d_prod = D_W'($signed({1'b0, deriv_gain})) * D_W'(e_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (q_pop && drive_enable) begin
				last_error_q <= e_res;
			end
			if (advance_s1) begin
				valid_s1 <= q_valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			e_s1      <= e_res;
			p_s1      <= p_prod;
			d_s1      <= d_prod;
			center_s1 <= q_word.center;
			lifted_s1 <= q_word.lifted;
			en_s1     <= drive_enable;
		end
		if (valid_s1 && advance_s2) begin
			duty_a_s2 <= duty_a;
			duty_b_s2 <= duty_b;
			e_s2      <= e_s1;
			lifted_s2 <= lifted_s1;
		end
	end

	assign base_scaled = SCALE_W'(base_speed) << GAIN_FRAC_BITS;
	assign base_w      = $signed(SUM_W'(base_scaled));
	assign corr        = SUM_W'(p_s1) + SUM_W'(d_s1);
	assign sum_a       = base_w - corr;
	assign sum_b       = base_w + corr;
	assign high_speed  = base_speed[DUTY_W-1] ? DUTY_MAX : {base_speed[DUTY_W-2:0], 1'b0};

	always_comb begin
		if (!en_s1 || lifted_s1) begin
			duty_a = '0;
			duty_b = '0;
		end else if (center_s1) begin
			duty_a = high_speed;
			duty_b = high_speed;
		end else begin
			duty_a = sat_duty(sum_a);
			duty_b = sat_duty(sum_b);
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OUT_W - 2*DUTY_W - ERR_W - 1)'(0), lifted_s2, e_s2,
		duty_b_s2, duty_a_s2};

endmodule

// ===== rtl/core/lfpd_checker.sv =====
// port-level checks of the pd line-follower drive unit, bound to the top level
module lfpd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [lfpd_pkg::OUT_W-1:0] m_axis_tdata
);
	import lfpd_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// a lifted robot never drives the motors
	a_lifted_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("duty non-zero while lifted");

	// line error stays within -6..6
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[19:16] != 4'd7 && m_axis_tdata[19:16] != 4'd8
			&& m_axis_tdata[19:16] != 4'd9)
		else $error("line error out of range");

	// nothing leaves the pipeline straight out of reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid right after reset");

endmodule

bind line_follow_pd_drive_unit lfpd_checker u_lfpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
